@@ src/rly_pkg.sv @@
// Shared types and constants for the relay output controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rly_pkg;

	// Milliseconds per second, used to scale the on-delay.
	localparam int unsigned MsPerSecond = 1000;

	// Field widths.
	localparam int unsigned ActionW   = 2;
	localparam int unsigned TimeW     = 32;
	localparam int unsigned DelayW    = 16;
	localparam int unsigned LimitW    = 26;   // 65535 * 1000 fits in 26 bits
	localparam int unsigned CfgIndexW = 2;

	// Actions carried by an input beat.
	typedef enum logic [ActionW-1:0] {
		ACT_EVALUATE    = 2'd0,
		ACT_TICK        = 2'd1,
		ACT_RESET_LATCH = 2'd2,
		ACT_WRITE_FLAG  = 2'd3
	} action_t;

	// Configuration register indexes.
	typedef enum logic [CfgIndexW-1:0] {
		CFG_DELAY_SECONDS = 2'd0,
		CFG_INVERT_OUTPUT = 2'd1,
		CFG_BYPASS_RELAY  = 2'd2,
		CFG_LATCH_MODE    = 2'd3
	} cfg_index_t;

	// One input beat.
	typedef struct packed {
		action_t            action;
		logic [TimeW-1:0]   now_ms;
		logic               trigger_valid;
		logic               trigger_value;
		logic               update_value;
	} item_t;

	// Configuration as seen by the core, with the delay already in milliseconds.
	typedef struct packed {
		logic [LimitW-1:0]  limit_ms;
		logic               delay_nonzero;
		logic               invert_output;
		logic               bypass_relay;
		logic               latch_mode;
	} cfg_t;

	// One result beat.
	typedef struct packed {
		logic               relay_out;
		logic               update_pending;
	} result_t;

endpackage

@@ src/rly_cfg.sv @@
// Configuration registers of the relay output controller.
// Depends on rly_pkg; scales the delay to milliseconds when it is written.
`timescale 1ns / 1ps

module rly_cfg
	import rly_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [DelayW-1:0]    cfg_wdata,
	output cfg_t                 cfg
);

	logic [LimitW-1:0] limit_q;
	logic              nonzero_q;
	logic              invert_q;
	logic              bypass_q;
	logic              latch_q;

	// Register writes; the delay is multiplied out here so the core only compares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= '0;
			nonzero_q <= 1'b0;
			invert_q  <= 1'b0;
			bypass_q  <= 1'b0;
			latch_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_DELAY_SECONDS: begin
					limit_q   <= LimitW'(LimitW'(cfg_wdata) * LimitW'(MsPerSecond));
					nonzero_q <= (cfg_wdata != '0);
				end
				CFG_INVERT_OUTPUT: invert_q <= cfg_wdata[0];
				CFG_BYPASS_RELAY:  bypass_q <= cfg_wdata[0];
				CFG_LATCH_MODE:    latch_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg.limit_ms      = limit_q;
	assign cfg.delay_nonzero = nonzero_q;
	assign cfg.invert_output = invert_q;
	assign cfg.bypass_relay  = bypass_q;
	assign cfg.latch_mode    = latch_q;

endmodule

@@ src/rly_core.sv @@
// Relay state and per-beat evaluation logic.
// Depends on rly_pkg; state advances only on beats that move to the output stage.
`timescale 1ns / 1ps

module rly_core
	import rly_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic             last_output_q;
	logic             delay_running_q;
	logic [TimeW-1:0] delay_start_q;
	logic             update_flag_q;

	logic             last_n;
	logic             running_n;
	logic             flag_n;
	logic             set_start;
	logic             cur;
	logic             relay;
	logic [TimeW-1:0] start_eff;
	logic [TimeW-1:0] diff;
	logic             expired;

	// Elapsed time against the start in effect for this beat; negative means not expired.
	assign start_eff = set_start ? item.now_ms : delay_start_q;
	assign diff      = item.now_ms - start_eff;
	assign expired   = !diff[TimeW-1] && (diff >= TimeW'(cfg.limit_ms));

	// Next state and result for the current beat.
	always_comb begin
		last_n    = last_output_q;
		running_n = delay_running_q;
		flag_n    = update_flag_q;
		set_start = 1'b0;
		cur       = 1'b0;
		relay     = 1'b0;
		unique case (item.action)
			ACT_EVALUATE: begin
				if (!cfg.bypass_relay && item.trigger_valid) begin
					if (cfg.latch_mode) begin
						if (item.trigger_value) begin
							cur = 1'b1;
							if (!last_output_q) begin
								running_n = 1'b1;
								set_start = 1'b1;
							end
							last_n = 1'b1;
						end else begin
							cur = last_output_q;
						end
					end else begin
						cur = item.trigger_value;
						if (!last_output_q && item.trigger_value) begin
							running_n = 1'b1;
							set_start = 1'b1;
						end
						if (last_output_q && !item.trigger_value) begin
							running_n = 1'b0;
						end
						last_n = item.trigger_value;
					end
				end
				// Hold the output low until the on-delay has run out.
				if (cur && running_n) begin
					if (expired) begin
						running_n = 1'b0;
					end else begin
						cur = 1'b0;
					end
				end
				relay = cur ^ cfg.invert_output;
			end
			ACT_TICK: begin
				if (delay_running_q && cfg.delay_nonzero && expired) begin
					flag_n = 1'b1;
				end
			end
			ACT_RESET_LATCH: begin
				if (cfg.latch_mode) begin
					last_n = 1'b0;
				end
				flag_n = 1'b1;
			end
			ACT_WRITE_FLAG: begin
				flag_n = item.update_value;
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_output_q   <= 1'b0;
			delay_running_q <= 1'b0;
			delay_start_q   <= '0;
			update_flag_q   <= 1'b1;
		end else if (fire) begin
			last_output_q   <= last_n;
			delay_running_q <= running_n;
			update_flag_q   <= flag_n;
			if (set_start) begin
				delay_start_q <= item.now_ms;
			end
		end
	end

	assign result.relay_out      = relay;
	assign result.update_pending = flag_n;

endmodule

@@ src/relay_output_controller.sv @@
// Relay output controller: drives one alarm relay from an evaluated trigger bit.
// Accepts one input beat per cycle while the output side does not stall, and presents one
// result beat for each through the input register, then the result register; the core
// update of relay state and the on-delay compare fit between those registers, so
// throughput is one beat per clock whenever the output side does not stall. Configuration
// must be written only while idle; the user is bound to this, the block does not enforce it.
// Depends on rly_pkg, rly_cfg and rly_core.
`timescale 1ns / 1ps

module relay_output_controller
	import rly_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ActionW-1:0]   action,
	input  logic [TimeW-1:0]     now_ms,
	input  logic                 trigger_valid,
	input  logic                 trigger_value,
	input  logic                 update_value,
	// Output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 relay_out,
	output logic                 update_pending,
	// Configuration port
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [DelayW-1:0]    cfg_wdata
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t result_s2;
	logic    valid_s2;
	logic    load_s2;
	logic    fire;
	logic    load_s1;

	// Handshake: each stage loads when it is empty or its content moves on.
	assign load_s2  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && load_s2;
	assign load_s1  = !valid_s1 || fire;
	assign in_stall = !load_s1;

	rly_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			item_s1.action        <= action_t'(action);
			item_s1.now_ms        <= now_ms;
			item_s1.trigger_valid <= trigger_valid;
			item_s1.trigger_value <= trigger_value;
			item_s1.update_value  <= update_value;
		end
	end

	rly_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result;
		end
	end

	assign out_valid      = valid_s2;
	assign relay_out      = result_s2.relay_out;
	assign update_pending = result_s2.update_pending;

endmodule

@@ bench/relay_output_controller_tb.sv @@
// Self-checking testbench for relay_output_controller: directed and random beats.
// A behavioral predictor built into the bench checks every result beat.
// Depends on rly_pkg and the relay_output_controller RTL.
`timescale 1ns / 1ps

module relay_output_controller_tb;
	import rly_pkg::*;

	localparam int WatchdogLimit = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	action_t               action;
	logic [TimeW-1:0]      now_ms;
	logic                  trigger_valid;
	logic                  trigger_value;
	logic                  update_value;
	logic                  out_valid;
	logic                  out_stall;
	logic                  relay_out;
	logic                  update_pending;
	logic                  cfg_we;
	cfg_index_t            cfg_index;
	logic [DelayW-1:0]     cfg_wdata;

	// Predictor copy of the configuration registers.
	logic [DelayW-1:0]     m_delay_s;
	logic                  m_invert;
	logic                  m_bypass;
	logic                  m_latch;

	// Predictor copy of the relay state.
	logic                  m_last_out;
	logic                  m_delay_run;
	logic [TimeW-1:0]      m_delay_start;
	logic                  m_update_flag;

	result_t               relay_results_due[$];
	int                    mismatch_count;
	int                    idle_cycles;
	bit                    calm;
	logic [TimeW-1:0]      clock_ms;

	relay_output_controller dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.now_ms         (now_ms),
		.trigger_valid  (trigger_valid),
		.trigger_value  (trigger_value),
		.update_value   (update_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.relay_out      (relay_out),
		.update_pending (update_pending),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata)
	);

	// 50 MHz clock.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The on-delay has run out when the signed elapsed time reaches the delay in ms.
	function automatic logic on_delay_done(logic [TimeW-1:0] t);
		logic [TimeW-1:0] elapsed;
		logic [TimeW-1:0] limit;
		elapsed = t - m_delay_start;
		limit = m_delay_s * MsPerSecond;
		return !elapsed[TimeW-1] && (elapsed >= limit);
	endfunction

	// Advances the predicted relay state by one beat and returns the result it yields.
	function automatic result_t next_relay_result(action_t act, logic [TimeW-1:0] t,
			logic tv, logic tg, logic uv);
		result_t r;
		logic cur;
		r = '0;
		cur = 1'b0;
		case (act)
			ACT_EVALUATE: begin
				if (!m_bypass && tv) begin
					if (m_latch) begin
						if (tg) begin
							cur = 1'b1;
							if (!m_last_out) begin
								m_delay_run = 1'b1;
								m_delay_start = t;
							end
							m_last_out = 1'b1;
						end else begin
							cur = m_last_out;
						end
					end else begin
						cur = tg;
						if (!m_last_out && cur) begin
							m_delay_run = 1'b1;
							m_delay_start = t;
						end
						if (m_last_out && !cur)
							m_delay_run = 1'b0;
						m_last_out = cur;
					end
				end
				// The output stays low while the on-delay is still running.
				if (cur && m_delay_run) begin
					if (on_delay_done(t))
						m_delay_run = 1'b0;
					else
						cur = 1'b0;
				end
				r.relay_out = cur ^ m_invert;
			end
			ACT_TICK: begin
				if (m_delay_run && m_delay_s != '0 && on_delay_done(t))
					m_update_flag = 1'b1;
			end
			ACT_RESET_LATCH: begin
				if (m_latch)
					m_last_out = 1'b0;
				m_update_flag = 1'b1;
			end
			default: begin
				m_update_flag = uv;
			end
		endcase
		r.update_pending = m_update_flag;
		return r;
	endfunction

	// Offers one beat, with random gaps before it, and records its prediction on acceptance.
	// Valid is left high so that a following beat can go out back to back.
	task automatic send_beat(action_t act, logic [TimeW-1:0] t, logic tv, logic tg, logic uv);
		while (!calm && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		now_ms        <= t;
		trigger_valid <= tv;
		trigger_value <= tg;
		update_value  <= uv;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		relay_results_due.push_back(next_relay_result(act, t, tv, tg, uv));
	endtask

	// Stops sending and waits until every predicted result has been delivered.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (relay_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all four registers; only called while the block is idle.
	task automatic load_config(logic [DelayW-1:0] d, logic inv, logic byp, logic lat);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DELAY_SECONDS;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_index <= CFG_INVERT_OUTPUT;
		cfg_wdata <= DelayW'(inv);
		@(posedge clk);
		cfg_index <= CFG_BYPASS_RELAY;
		cfg_wdata <= DelayW'(byp);
		@(posedge clk);
		cfg_index <= CFG_LATCH_MODE;
		cfg_wdata <= DelayW'(lat);
		@(posedge clk);
		cfg_we    <= 1'b0;
		m_delay_s = d;
		m_invert  = inv;
		m_bypass  = byp;
		m_latch   = lat;
	endtask

	// Following mode with no on-delay, flag writes, a tick that must not raise the flag
	// and a latch reset outside latching mode.
	task automatic test_delay_free_path();
		load_config(16'd0, 1'b0, 1'b0, 1'b0);
		send_beat(ACT_WRITE_FLAG, 32'd0, 1'b0, 1'b0, 1'b0);
		send_beat(ACT_EVALUATE, 32'd0, 1'b1, 1'b1, 1'b0);
		send_beat(ACT_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
		send_beat(ACT_EVALUATE, 32'h8000_0000, 1'b1, 1'b0, 1'b1);
		send_beat(ACT_RESET_LATCH, 32'h5555_5555, 1'b0, 1'b1, 1'b0);
		drain_results();
	endtask

	// One-second on-delay in energized mode: expiry by tick and by evaluate,
	// a timestamp before the start, and an invalid trigger.
	task automatic test_on_delay_expiry();
		load_config(16'd1, 1'b1, 1'b0, 1'b0);
		send_beat(ACT_WRITE_FLAG, 32'd0, 1'b0, 1'b0, 1'b0);
		send_beat(ACT_EVALUATE, 32'd0, 1'b1, 1'b0, 1'b0);
		send_beat(ACT_EVALUATE, 32'd1000, 1'b1, 1'b1, 1'b0);
		send_beat(ACT_TICK, 32'd1500, 1'b1, 1'b1, 1'b0);
		send_beat(ACT_TICK, 32'd2000, 1'b1, 1'b1, 1'b0);
		send_beat(ACT_EVALUATE, 32'd500, 1'b1, 1'b1, 1'b0);
		send_beat(ACT_EVALUATE, 32'd2000, 1'b1, 1'b1, 1'b0);
		send_beat(ACT_EVALUATE, 32'd2100, 1'b0, 1'b0, 1'b1);
		drain_results();
	endtask

	// Bypass with the longest delay, then latching across the timestamp wrap.
	task automatic test_latching_and_bypass();
		load_config(16'hFFFF, 1'b0, 1'b1, 1'b1);
		send_beat(ACT_EVALUATE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
		drain_results();
		load_config(16'hFFFF, 1'b0, 1'b0, 1'b1);
		send_beat(ACT_RESET_LATCH, 32'd0, 1'b0, 1'b0, 1'b0);
		send_beat(ACT_WRITE_FLAG, 32'd0, 1'b0, 1'b0, 1'b0);
		send_beat(ACT_EVALUATE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
		send_beat(ACT_EVALUATE, 32'd0, 1'b1, 1'b0, 1'b0);
		send_beat(ACT_TICK, 32'd65534998, 1'b0, 1'b0, 1'b0);
		send_beat(ACT_TICK, 32'd65534999, 1'b0, 1'b0, 1'b0);
		send_beat(ACT_EVALUATE, 32'd65534999, 1'b1, 1'b1, 1'b0);
		send_beat(ACT_RESET_LATCH, 32'd65535000, 1'b1, 1'b1, 1'b1);
		send_beat(ACT_EVALUATE, 32'd65535001, 1'b1, 1'b0, 1'b0);
		drain_results();
	endtask

	// Phases of random beats on a mostly advancing millisecond clock, each under a
	// fresh configuration; one phase runs without idling, another pauses midway.
	task automatic test_random_traffic();
		logic [DelayW-1:0] d;
		logic inv;
		logic byp;
		logic lat;
		int pick;
		action_t act;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					d = 16'd0; inv = 1'b0; byp = 1'b0; lat = 1'b0;
				end
				1: begin
					d = 16'hFFFF; inv = 1'b1; byp = 1'b0; lat = 1'b1;
				end
				2: begin
					d = 16'd1; inv = 1'b0; byp = 1'b1; lat = 1'b0;
				end
				default: begin
					pick = int'($urandom_range(99));
					if (pick < 60)
						d = DelayW'($urandom_range(3, 1));
					else if (pick < 75)
						d = 16'd0;
					else if (pick < 85)
						d = 16'hFFFF;
					else
						d = DelayW'($urandom_range(16'hFFFF, 0));
					inv = 1'($urandom_range(1));
					byp = ($urandom_range(5) == 0);
					lat = 1'($urandom_range(1));
				end
			endcase
			load_config(d, inv, byp, lat);
			calm = (phase == 3);
			clock_ms = (phase == 4) ? 32'hFFFF_F000 : $urandom();
			for (int n = 0; n < 100; n++) begin
				// Mostly forward steps; sometimes a step back or a jump anywhere.
				pick = int'($urandom_range(99));
				if (pick < 5)
					clock_ms = clock_ms - $urandom_range(3000, 1);
				else if (pick < 8)
					clock_ms = $urandom();
				else
					clock_ms = clock_ms + $urandom_range(700, 0);
				pick = int'($urandom_range(99));
				if (pick < 50)
					act = ACT_EVALUATE;
				else if (pick < 75)
					act = ACT_TICK;
				else if (pick < 85)
					act = ACT_RESET_LATCH;
				else
					act = ACT_WRITE_FLAG;
				send_beat(act, clock_ms, ($urandom_range(9) != 0), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				if (phase == 5 && n == 50)
					drain_results();
			end
			drain_results();
			calm = 1'b0;
		end
	endtask

	// The output side stalls at random, except during the calm phase.
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 16);

	// Compare each delivered result beat with the oldest prediction.
	always @(posedge clk) begin
		result_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (relay_results_due.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got relay_out=%b update_pending=%b",
					$time, relay_out, update_pending);
				mismatch_count++;
			end else begin
				due = relay_results_due.pop_front();
				if (relay_out !== due.relay_out) begin
					$display("%0t: relay_out expected %b, got %b", $time, due.relay_out, relay_out);
					mismatch_count++;
				end
				if (update_pending !== due.update_pending) begin
					$display("%0t: update_pending expected %b, got %b", $time,
						due.update_pending, update_pending);
					mismatch_count++;
				end
			end
		end
	end

	// End the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		action         = ACT_EVALUATE;
		now_ms         = '0;
		trigger_valid  = 1'b0;
		trigger_value  = 1'b0;
		update_value   = 1'b0;
		out_stall      = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_DELAY_SECONDS;
		cfg_wdata      = '0;
		calm           = 1'b0;
		mismatch_count = 0;
		idle_cycles    = 0;
		m_delay_s      = '0;
		m_invert       = 1'b0;
		m_bypass       = 1'b0;
		m_latch        = 1'b0;
		m_last_out     = 1'b0;
		m_delay_run    = 1'b0;
		m_delay_start  = '0;
		m_update_flag  = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_delay_free_path();
		test_on_delay_expiry();
		test_latching_and_bypass();
		test_random_traffic();
		drain_results();

		if (mismatch_count == 0 && relay_results_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ relay_output_controller.f @@
src/rly_pkg.sv
src/rly_cfg.sv
src/rly_core.sv
src/relay_output_controller.sv
bench/relay_output_controller_tb.sv
